[sv/tsd_pkg.sv]
package tsd_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_DISTANCE_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_SLOPE_RATIO        = 2'd1;
    localparam logic [1:0] REG_MAX_DURATION_MS    = 2'd2;
    localparam logic [1:0] REG_RELEASE_GAP_MS     = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Gesture codes reported with each result.
    localparam logic [1:0] GESTURE_NONE     = 2'd0;
    localparam logic [1:0] GESTURE_NEXT     = 2'd1;
    localparam logic [1:0] GESTURE_PREVIOUS = 2'd2;
    localparam logic [1:0] GESTURE_REJECTED = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [9:0]  DISTANCE_THRESHOLD_RST = 10'd90;
    localparam logic [3:0]  SLOPE_RATIO_RST        = 4'd2;
    localparam logic [15:0] MAX_DURATION_MS_RST    = 16'd1200;
    localparam logic [15:0] RELEASE_GAP_MS_RST     = 16'd80;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 160;

    typedef struct packed {
        logic [9:0]  distance_threshold;
        logic [3:0]  slope_ratio;
        logic [15:0] max_duration_ms;
        logic [15:0] release_gap_ms;
    } cfg_t;

    // One touch poll, last field in the lowest bits.
    typedef struct packed {
        logic [31:0] now_ms;
        logic [9:0]  pos_y;
        logic [9:0]  pos_x;
        logic        touched;
    } poll_t;

    // One result, last field in the lowest bits.
    typedef struct packed {
        logic [31:0]        reject_count;
        logic [31:0]        accept_count;
        logic [31:0]        press_count;
        logic [31:0]        touch_count;
        logic signed [10:0] delta_y;
        logic signed [10:0] delta_x;
        logic               screen;
        logic [1:0]         gesture;
    } result_t;

endpackage

[sv/tsd_cfg.sv]
module tsd_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [tsd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tsd_pkg::CFG_DATA_W-1:0]      cfg_data,
    output tsd_pkg::cfg_t                       cfg
);
    import tsd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_DISTANCE_THRESHOLD: cfg_next.distance_threshold = cfg_data[9:0];
                REG_SLOPE_RATIO:        cfg_next.slope_ratio        = cfg_data[3:0];
                REG_MAX_DURATION_MS:    cfg_next.max_duration_ms    = cfg_data;
                REG_RELEASE_GAP_MS:     cfg_next.release_gap_ms     = cfg_data;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.distance_threshold <= DISTANCE_THRESHOLD_RST;
            cfg_reg.slope_ratio        <= SLOPE_RATIO_RST;
            cfg_reg.max_duration_ms    <= MAX_DURATION_MS_RST;
            cfg_reg.release_gap_ms     <= RELEASE_GAP_MS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/tsd_core.sv]
module tsd_core #(
    parameter int SCREEN_COUNT = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  tsd_pkg::poll_t    poll,
    input  tsd_pkg::cfg_t     cfg,
    output tsd_pkg::result_t  result
);
    import tsd_pkg::*;

    localparam int SCREEN_W = (SCREEN_COUNT > 1) ? $clog2(SCREEN_COUNT) : 1;
    localparam logic [SCREEN_W-1:0] SCREEN_LAST = SCREEN_W'(SCREEN_COUNT - 1);

    logic                pressed_reg, pressed_next;
    logic                swiped_reg, swiped_next;
    logic [9:0]          start_x_reg, start_x_next;
    logic [9:0]          start_y_reg, start_y_next;
    logic [9:0]          last_x_reg, last_x_next;
    logic [9:0]          last_y_reg, last_y_next;
    logic [31:0]         start_time_reg, start_time_next;
    logic [31:0]         last_touch_reg, last_touch_next;
    logic [SCREEN_W-1:0] screen_reg, screen_next;
    logic signed [10:0]  judged_dx_reg, judged_dx_next;
    logic signed [10:0]  judged_dy_reg, judged_dy_next;
    logic [31:0]         touch_cnt_reg, touch_cnt_next;
    logic [31:0]         press_cnt_reg, press_cnt_next;
    logic [31:0]         accept_cnt_reg, accept_cnt_next;
    logic [31:0]         reject_cnt_reg, reject_cnt_next;

    logic [9:0]          pt_x, pt_y;
    logic signed [10:0]  dx, dy;
    logic [9:0]          adx, ady;
    logic [13:0]         slope_limit;
    logic [31:0]         duration, gap;
    logic                dist_ok, slope_ok, time_ok, swipe_ok, released;
    logic [1:0]          gesture;

    // The touched point during a press, the stored last point on release.
    assign pt_x = poll.touched ? poll.pos_x : last_x_reg;
    assign pt_y = poll.touched ? poll.pos_y : last_y_reg;

    assign dx  = $signed({1'b0, pt_x}) - $signed({1'b0, start_x_reg});
    assign dy  = $signed({1'b0, pt_y}) - $signed({1'b0, start_y_reg});
    assign adx = dx[10] ? 10'(-dx) : dx[9:0];
    assign ady = dy[10] ? 10'(-dy) : dy[9:0];

    assign slope_limit = cfg.slope_ratio * ady;
    assign duration    = poll.now_ms - start_time_reg;
    assign gap         = poll.now_ms - last_touch_reg;

    assign dist_ok  = adx >= cfg.distance_threshold;
    assign slope_ok = {4'b0, adx} > slope_limit;
    assign time_ok  = duration <= {16'b0, cfg.max_duration_ms};
    assign swipe_ok = dist_ok && slope_ok && time_ok;
    assign released = !poll.touched && pressed_reg && (gap > {16'b0, cfg.release_gap_ms});

    always_comb begin
        pressed_next    = pressed_reg;
        swiped_next     = swiped_reg;
        start_x_next    = start_x_reg;
        start_y_next    = start_y_reg;
        last_x_next     = last_x_reg;
        last_y_next     = last_y_reg;
        start_time_next = start_time_reg;
        last_touch_next = last_touch_reg;
        screen_next     = screen_reg;
        judged_dx_next  = judged_dx_reg;
        judged_dy_next  = judged_dy_reg;
        touch_cnt_next  = touch_cnt_reg;
        press_cnt_next  = press_cnt_reg;
        accept_cnt_next = accept_cnt_reg;
        reject_cnt_next = reject_cnt_reg;
        gesture         = GESTURE_NONE;

        if (poll.touched) begin
            touch_cnt_next  = touch_cnt_reg + 32'd1;
            last_touch_next = poll.now_ms;
            last_x_next     = poll.pos_x;
            last_y_next     = poll.pos_y;
            if (!pressed_reg) begin
                pressed_next    = 1'b1;
                swiped_next     = 1'b0;
                start_x_next    = poll.pos_x;
                start_y_next    = poll.pos_y;
                start_time_next = poll.now_ms;
                press_cnt_next  = press_cnt_reg + 32'd1;
            end else if (!swiped_reg && swipe_ok) begin
                swiped_next = 1'b1;
                gesture     = dx[10] ? GESTURE_NEXT : GESTURE_PREVIOUS;
            end
        end else if (released) begin
            pressed_next = 1'b0;
            if (!swiped_reg) begin
                gesture = swipe_ok ? (dx[10] ? GESTURE_NEXT : GESTURE_PREVIOUS)
                                   : GESTURE_REJECTED;
            end
        end

        // A judged gesture records its travel; a swipe moves the screen within range.
        if (gesture != GESTURE_NONE) begin
            judged_dx_next = dx;
            judged_dy_next = dy;
        end
        if (gesture == GESTURE_REJECTED) begin
            reject_cnt_next = reject_cnt_reg + 32'd1;
        end
        if (gesture == GESTURE_NEXT || gesture == GESTURE_PREVIOUS) begin
            accept_cnt_next = accept_cnt_reg + 32'd1;
        end
        if (gesture == GESTURE_NEXT && screen_reg != SCREEN_LAST) begin
            screen_next = screen_reg + SCREEN_W'(1);
        end
        if (gesture == GESTURE_PREVIOUS && screen_reg != '0) begin
            screen_next = screen_reg - SCREEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressed_reg    <= 1'b0;
            swiped_reg     <= 1'b0;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            start_time_reg <= '0;
            last_touch_reg <= '0;
            screen_reg     <= '0;
            judged_dx_reg  <= '0;
            judged_dy_reg  <= '0;
            touch_cnt_reg  <= '0;
            press_cnt_reg  <= '0;
            accept_cnt_reg <= '0;
            reject_cnt_reg <= '0;
        end else if (step) begin
            pressed_reg    <= pressed_next;
            swiped_reg     <= swiped_next;
            start_x_reg    <= start_x_next;
            start_y_reg    <= start_y_next;
            last_x_reg     <= last_x_next;
            last_y_reg     <= last_y_next;
            start_time_reg <= start_time_next;
            last_touch_reg <= last_touch_next;
            screen_reg     <= screen_next;
            judged_dx_reg  <= judged_dx_next;
            judged_dy_reg  <= judged_dy_next;
            touch_cnt_reg  <= touch_cnt_next;
            press_cnt_reg  <= press_cnt_next;
            accept_cnt_reg <= accept_cnt_next;
            reject_cnt_reg <= reject_cnt_next;
        end
    end

    assign result.gesture      = gesture;
    assign result.screen       = screen_next[0];
    assign result.delta_x      = judged_dx_next;
    assign result.delta_y      = judged_dy_next;
    assign result.touch_count  = touch_cnt_next;
    assign result.press_count  = press_cnt_next;
    assign result.accept_count = accept_cnt_next;
    assign result.reject_count = reject_cnt_next;

    // The active screen never leaves the configured range.
    a_screen_range: assert property (@(posedge aclk) disable iff (!aresetn)
        screen_reg <= SCREEN_LAST)
        else $error("active screen out of range");

    // Every accepted swipe is counted exactly once.
    a_accept_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (gesture == GESTURE_NEXT || gesture == GESTURE_PREVIOUS)
        |=> accept_cnt_reg == $past(accept_cnt_reg) + 32'd1)
        else $error("accepted swipe not counted");

    // A rejection can only end an open press that had no swipe yet.
    a_reject_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        step && gesture == GESTURE_REJECTED |-> pressed_reg && !swiped_reg && !poll.touched)
        else $error("rejection without an open press");

    // State holds while no poll is evaluated.
    a_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(touch_cnt_reg) && $stable(pressed_reg) && $stable(screen_reg))
        else $error("state changed without a poll");

endmodule

[sv/touch_swipe_detector_unit.sv]
// Horizontal swipe detector for a touch panel. Each request on the input stream is one poll
// (touched flag, x, y and a wrapping millisecond time); each poll produces exactly one result
// request carrying the gesture code (none, next, previous, rejected on release), the active
// screen, the travel of the last judged gesture and four wrapping event counters. A swipe is
// accepted during the press as soon as it passes the distance, slope and duration tests;
// otherwise it is judged when the press ends, which is a no-touch poll arriving more than
// release_gap_ms after the last touch. The block takes one poll per clock cycle while the
// output is not stalled: the poll is held in an input register, evaluated by a single
// pass of subtract, multiply and compare logic against the press state, and the result
// lands in an output register until it is taken. A stalled output only holds the input
// register; a new poll is still taken in the cycle that the waiting result leaves.
// The user must write configuration registers through the write port while no poll is in
// flight; the block does not enforce this. They reset to 90 px, ratio 2, 1200 ms and 80 ms.
module touch_swipe_detector_unit #(
    parameter int SCREEN_COUNT = 2
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_wr_en,
    input  logic [tsd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [tsd_pkg::CFG_DATA_W-1:0]       cfg_data,

    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // touched[0], pos_x[10:1], pos_y[20:11], now_ms[52:21], zero fill[55:53]
    input  logic [tsd_pkg::IN_TDATA_W-1:0]       s_axis_tdata,

    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // gesture[1:0], screen[2], delta_x[13:3], delta_y[24:14], touch_count[56:25],
    // press_count[88:57], accept_count[120:89], reject_count[152:121], zero fill[159:153]
    output logic [tsd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
    import tsd_pkg::*;

    cfg_t    cfg;
    poll_t   poll_reg;
    logic    poll_valid_reg, poll_valid_next;
    result_t result;
    result_t result_reg;
    logic    out_valid_reg, out_valid_next;
    logic    advance;
    logic    in_take;

    tsd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The poll in the input register is evaluated when the output register is free or
    // its result is being taken in this cycle.
    assign advance       = poll_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !poll_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    tsd_core #(
        .SCREEN_COUNT (SCREEN_COUNT)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .poll    (poll_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_comb begin
        poll_valid_next = poll_valid_reg;
        if (in_take) begin
            poll_valid_next = 1'b1;
        end else if (advance) begin
            poll_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poll_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            poll_valid_reg <= poll_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers carry no reset; they are qualified by the valid flags.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            poll_reg <= poll_t'(s_axis_tdata[$bits(poll_t)-1:0]);
        end
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - $bits(result_t))'(0), result_reg};

endmodule

[tb/touch_swipe_detector_unit_test.sv]
`timescale 1ns / 100ps

module touch_swipe_detector_unit_test;

    import tsd_pkg::*;

    localparam int SCREEN_COUNT = 2;
    // Twelve register settings are run, each with at least this many polls of random traffic.
    localparam int POLLS_PER_SETTING = 100;

    // The scoreboard keeps its own copy of the press state, the counters and the
    // configuration. Every accepted poll turns into exactly one expected result.
    class swipe_scoreboard;
        logic [9:0]         min_travel;
        logic [3:0]         slope_ratio;
        logic [15:0]        max_duration;
        logic [15:0]        release_gap;
        logic               pressed;
        logic               swiped;
        logic [9:0]         start_x;
        logic [9:0]         start_y;
        logic [9:0]         last_x;
        logic [9:0]         last_y;
        logic [31:0]        start_ms;
        logic [31:0]        last_touch_ms;
        int                 screen_idx;
        logic signed [10:0] judged_dx;
        logic signed [10:0] judged_dy;
        logic [31:0]        touches;
        logic [31:0]        presses;
        logic [31:0]        accepts;
        logic [31:0]        rejects;
        result_t            pending_results[$];
        int                 errors;
        int                 checked;
        int                 gesture_seen[4];

        function new();
            min_travel    = DISTANCE_THRESHOLD_RST;
            slope_ratio   = SLOPE_RATIO_RST;
            max_duration  = MAX_DURATION_MS_RST;
            release_gap   = RELEASE_GAP_MS_RST;
            pressed       = 1'b0;
            swiped        = 1'b0;
            start_x       = '0;
            start_y       = '0;
            last_x        = '0;
            last_y        = '0;
            start_ms      = '0;
            last_touch_ms = '0;
            screen_idx    = 0;
            judged_dx     = '0;
            judged_dy     = '0;
            touches       = '0;
            presses       = '0;
            accepts       = '0;
            rejects       = '0;
            errors        = 0;
            checked       = 0;
            gesture_seen  = '{0, 0, 0, 0};
        endfunction

        // Only the low bits of the distance and slope registers are kept.
        function void write_reg(logic [1:0] idx, logic [15:0] value);
            case (idx)
                REG_DISTANCE_THRESHOLD: min_travel   = value[9:0];
                REG_SLOPE_RATIO:        slope_ratio  = value[3:0];
                REG_MAX_DURATION_MS:    max_duration = value;
                REG_RELEASE_GAP_MS:     release_gap  = value;
                default: ;
            endcase
        endfunction

        // Distance, slope and duration rules, with time taken modulo 2^32.
        function bit swipe_ok(int dx, int dy, logic [31:0] now_ms);
            int          adx;
            int          ady;
            logic [31:0] held;
            adx  = (dx < 0) ? -dx : dx;
            ady  = (dy < 0) ? -dy : dy;
            held = now_ms - start_ms;
            return adx >= int'(min_travel) && adx > int'(slope_ratio) * ady &&
                   held <= 32'(max_duration);
        endfunction

        // A move past either end of the screen range is dropped but still counted.
        function logic [1:0] step_screen(int dx);
            int target;
            target = (dx < 0) ? screen_idx + 1 : screen_idx - 1;
            accepts += 1;
            if (target >= 0 && target < SCREEN_COUNT) begin
                screen_idx = target;
            end
            return (dx < 0) ? GESTURE_NEXT : GESTURE_PREVIOUS;
        endfunction

        function void note_poll(poll_t p);
            result_t    r;
            logic [1:0] g;
            int         dx;
            int         dy;
            g = GESTURE_NONE;
            if (p.touched) begin
                touches += 1;
                last_touch_ms = p.now_ms;
                if (!pressed) begin
                    pressed  = 1'b1;
                    swiped   = 1'b0;
                    start_x  = p.pos_x;
                    start_y  = p.pos_y;
                    last_x   = p.pos_x;
                    last_y   = p.pos_y;
                    start_ms = p.now_ms;
                    presses += 1;
                end else begin
                    last_x = p.pos_x;
                    last_y = p.pos_y;
                    if (!swiped) begin
                        dx = int'(last_x) - int'(start_x);
                        dy = int'(last_y) - int'(start_y);
                        if (swipe_ok(dx, dy, p.now_ms)) begin
                            judged_dx = dx[10:0];
                            judged_dy = dy[10:0];
                            swiped    = 1'b1;
                            g         = step_screen(dx);
                        end
                    end
                end
            end else if (pressed && (p.now_ms - last_touch_ms) > 32'(release_gap)) begin
                pressed = 1'b0;
                if (!swiped) begin
                    dx = int'(last_x) - int'(start_x);
                    dy = int'(last_y) - int'(start_y);
                    judged_dx = dx[10:0];
                    judged_dy = dy[10:0];
                    if (swipe_ok(dx, dy, p.now_ms)) begin
                        g = step_screen(dx);
                    end else begin
                        rejects += 1;
                        g = GESTURE_REJECTED;
                    end
                end
            end
            r.gesture      = g;
            r.screen       = screen_idx[0];
            r.delta_x      = judged_dx;
            r.delta_y      = judged_dy;
            r.touch_count  = touches;
            r.press_count  = presses;
            r.accept_count = accepts;
            r.reject_count = rejects;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic signed [63:0] want_v,
                                    logic signed [63:0] got_v);
            if (got_v !== want_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want_v, got_v);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with no poll outstanding, expected none, actual %h",
                         $time, got);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            gesture_seen[want.gesture]++;
            compare_field("gesture", 64'(want.gesture), 64'(got.gesture));
            compare_field("screen", 64'(want.screen), 64'(got.screen));
            compare_field("delta_x", 64'(want.delta_x), 64'(got.delta_x));
            compare_field("delta_y", 64'(want.delta_y), 64'(got.delta_y));
            compare_field("touch_count", 64'(want.touch_count), 64'(got.touch_count));
            compare_field("press_count", 64'(want.press_count), 64'(got.press_count));
            compare_field("accept_count", 64'(want.accept_count), 64'(got.accept_count));
            compare_field("reject_count", 64'(want.reject_count), 64'(got.reject_count));
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    swipe_scoreboard sb;

    // Percent of cycles in which each side holds off; changed per pacing phase.
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          polls_sent = 0;
    // Running panel time used to build coherent gestures.
    logic [31:0] clock_ms = '0;

    touch_swipe_detector_unit #(
        .SCREEN_COUNT(SCREEN_COUNT)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The result side is throttled by a random draw each cycle, so stalls can land on
    // any cycle of the two-stage pipeline, including the one where a new poll enters.
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Results are sampled at the rising edge, when the handshake actually happens.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(result_t'(m_axis_tdata[$bits(result_t)-1:0]));
        end
    end

    function automatic int clamp_pixel(int v);
        return (v < 0) ? 0 : ((v > 1023) ? 1023 : v);
    endfunction

    // Sends one poll request. It is entered and left at a falling edge; tvalid stays
    // high between back-to-back requests unless the sender chooses to hold off.
    task automatic drive_poll(bit touched, int x, int y, logic [31:0] now_ms);
        poll_t p;
        p.touched = touched;
        p.pos_x   = x[9:0];
        p.pos_y   = y[9:0];
        p.now_ms  = now_ms;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - $bits(poll_t)){1'b0}}, p};
        do begin
            @(posedge aclk);
        end while (!s_axis_tready);
        sb.note_poll(p);
        polls_sent++;
        @(negedge aclk);
    endtask

    // A poll with every field random. Its time may jump backward or far ahead,
    // which reaches the wrapping paths of the duration and gap tests.
    task automatic noise_poll();
        drive_poll(1'($urandom_range(1)), $urandom_range(1023), $urandom_range(1023),
                   $urandom());
    endtask

    // One press built from the current register values: a start point, a few moves
    // towards a goal, optional short lift-offs that stay inside the release gap, and
    // usually a release. Travel, slope and duration straddle the limits on purpose.
    task automatic random_swipe();
        int          x0;
        int          y0;
        int          mag;
        int          dx_goal;
        int          dy_goal;
        int          jitter;
        int          span;
        int          steps;
        int          k;
        logic [31:0] t0;
        logic [31:0] t_last;
        x0  = $urandom_range(1023);
        y0  = $urandom_range(1023);
        mag = ($urandom_range(3) == 0) ? $urandom_range(1023)
                                       : $urandom_range(1023, sb.min_travel);
        dx_goal = $urandom_range(1) ? mag : -mag;
        if ($urandom_range(4) == 0) begin
            dy_goal = $urandom_range(1023);
            dy_goal = dy_goal - 512;
        end else begin
            dy_goal = $urandom_range(mag / (sb.slope_ratio + 1));
            if ($urandom_range(1)) begin
                dy_goal = -dy_goal;
            end
        end
        span  = ($urandom_range(3) != 0) ? $urandom_range(sb.max_duration)
                                         : sb.max_duration + $urandom_range(3000, 1);
        steps = $urandom_range(6, 1);
        t0    = clock_ms;
        drive_poll(1'b1, x0, y0, t0);
        t_last = t0;
        for (k = 1; k <= steps; k++) begin
            if ($urandom_range(5) == 0) begin
                drive_poll(1'b0, $urandom_range(1023), $urandom_range(1023),
                           t_last + $urandom_range(sb.release_gap));
            end
            jitter = $urandom_range(2);
            jitter = jitter - 1;
            t_last = t0 + span * k / steps;
            drive_poll(1'b1, clamp_pixel(x0 + dx_goal * k / steps),
                       clamp_pixel(y0 + dy_goal * k / steps + jitter), t_last);
        end
        // Now and then the press is left open, so the next one merges into it.
        if ($urandom_range(9) != 0) begin
            if ($urandom_range(2) == 0) begin
                drive_poll(1'b0, $urandom_range(1023), $urandom_range(1023),
                           t_last + sb.release_gap);
            end
            t_last = t_last + sb.release_gap + $urandom_range(200, 1);
            drive_poll(1'b0, $urandom_range(1023), $urandom_range(1023), t_last);
        end
        clock_ms = t_last + $urandom_range(50);
    endtask

    // Registers may only change with nothing in flight: stop sending, wait for every
    // expected result, then let the two-stage pipeline sit idle before the writes.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    // Setting 0 is the reset set, 1 the lowest values with junk above the narrow
    // fields, 2 the highest values, 3 fully random.
    task automatic program_registers(int setting);
        logic [15:0] vals[4];
        logic [1:0]  regs[4];
        int          k;
        regs = '{REG_DISTANCE_THRESHOLD, REG_SLOPE_RATIO, REG_MAX_DURATION_MS,
                 REG_RELEASE_GAP_MS};
        case (setting)
            0: vals = '{16'(DISTANCE_THRESHOLD_RST), 16'(SLOPE_RATIO_RST),
                        MAX_DURATION_MS_RST, RELEASE_GAP_MS_RST};
            1: vals = '{{6'($urandom), 10'd0}, {12'($urandom), 4'd0}, 16'd0, 16'd0};
            2: vals = '{16'h03FF, 16'h000F, 16'hFFFF, 16'hFFFF};
            default: vals = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
        endcase
        for (k = 0; k < 4; k++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            sb.write_reg(regs[k], vals[k]);
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Safety net in case the block stops handshaking; far above the slowest correct run.
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int phase;
        int setting;
        int first_poll;
        sb = new();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 18;
        recv_idle_pct = 84;

        // Directed presses under the reset registers (90 px, ratio 2, 1200 ms, 80 ms).
        // Time starts just below the wrap point, so the first swipe spans it.
        clock_ms = 32'hFFFF_FF00;
        drive_poll(1'b0, 0, 0, clock_ms);                    // no press, nothing happens
        drive_poll(1'b1, 1023, 0, clock_ms);                 // press at the right edge
        clock_ms += 1200;
        drive_poll(1'b1, 933, 0, clock_ms);                  // exactly 90 px in 1200 ms: next
        clock_ms += 10;
        drive_poll(1'b1, 0, 1023, clock_ms);                 // already swiped, only counted
        drive_poll(1'b0, 1023, 1023, clock_ms + 80);         // gap equal to limit holds press
        drive_poll(1'b0, 0, 0, clock_ms + 81);               // release after accepted swipe
        clock_ms += 200;
        drive_poll(1'b1, 0, 512, clock_ms);
        drive_poll(1'b1, 1023, 512, clock_ms + 5);           // full-width travel: previous
        clock_ms += 300;
        drive_poll(1'b0, 0, 0, clock_ms);
        // Previous while already on the first screen: accepted, screen stays.
        drive_poll(1'b1, 500, 500, clock_ms + 1);
        drive_poll(1'b1, 700, 510, clock_ms + 2);
        clock_ms += 100;
        drive_poll(1'b0, 0, 0, clock_ms);
        drive_poll(1'b1, 500, 500, clock_ms + 1);
        drive_poll(1'b1, 300, 500, clock_ms + 2);            // next, onto the last screen
        clock_ms += 100;
        drive_poll(1'b0, 0, 0, clock_ms);
        drive_poll(1'b1, 500, 500, clock_ms + 1);
        drive_poll(1'b1, 100, 500, clock_ms + 2);            // next past the last screen
        clock_ms += 100;
        drive_poll(1'b0, 0, 0, clock_ms);
        // Too steep: travel equals ratio times rise, rejected on release.
        drive_poll(1'b1, 100, 100, clock_ms + 1);
        drive_poll(1'b1, 300, 0, clock_ms + 2);
        clock_ms += 100;
        drive_poll(1'b0, 0, 0, clock_ms);
        // Too slow by one millisecond, rejected on release.
        drive_poll(1'b1, 100, 600, clock_ms + 1);
        drive_poll(1'b1, 195, 647, clock_ms + 1202);
        drive_poll(1'b0, 0, 0, clock_ms + 1202 + 81);
        clock_ms += 2000;
        // Time runs backward at the release: the wrapped gap ends the press and the
        // short duration lets the release judge the swipe as accepted.
        drive_poll(1'b1, 200, 300, clock_ms);
        drive_poll(1'b1, 100, 300, clock_ms + 1300);
        drive_poll(1'b0, 0, 0, clock_ms + 5);
        clock_ms += 2000;

        // Random traffic: three pacing phases, four register settings in each.
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 18;
                    recv_idle_pct = 84;
                end
                1: begin
                    send_idle_pct = 84;
                    recv_idle_pct = 18;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (setting = 0; setting < 4; setting++) begin
                settle();
                program_registers(setting);
                clock_ms   = $urandom();
                first_poll = polls_sent;
                while (polls_sent - first_poll < POLLS_PER_SETTING) begin
                    if ($urandom_range(99) < 85) begin
                        random_swipe();
                    end else begin
                        repeat ($urandom_range(3, 1)) noise_poll();
                    end
                end
            end
        end

        settle();
        repeat (10) @(negedge aclk);
        $display("Ran %0d polls through 12 register settings and three pacing phases;",
                 polls_sent);
        $display("%0d results compared.", sb.checked);
        $display("Gestures: %0d next, %0d previous, %0d rejected, %0d none; %0d mismatches.",
                 sb.gesture_seen[GESTURE_NEXT], sb.gesture_seen[GESTURE_PREVIOUS],
                 sb.gesture_seen[GESTURE_REJECTED], sb.gesture_seen[GESTURE_NONE], sb.errors);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
